// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The response must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, cond, resp, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (resp)) \
		else $error(msg);

// The response must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, resp, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (resp)) \
		else $error(msg);

`endif

// ===== rtl/lpmm_pkg.sv =====
`timescale 1ns / 1ps
package lpmm_pkg;

	localparam int MAX_ITEMS_DEF   = 64;
	localparam int MAX_GROUPS_DEF  = 16;
	localparam int VALUE_WIDTH_DEF = 16;

	// Width of the group count register and its value after reset.
	localparam int               CFG_W           = 5;
	localparam logic [CFG_W-1:0] GROUP_COUNT_RST = CFG_W'(4);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW,
		ST_PI,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_WALK,
		ST_WALK_NEXT,
		ST_EMIT,
		ST_FLUSH
	} lpmm_state_t;

	typedef struct packed {
		logic valid;
		logic restart;
	} scan_ctl_t;

endpackage

// ===== rtl/lpmm_scan.sv =====
`timescale 1ns / 1ps
module lpmm_scan import lpmm_pkg::*; #(
	parameter int SUM_W = VALUE_WIDTH_DEF + $clog2(MAX_ITEMS_DEF),
	parameter int IDX_W = $clog2(MAX_ITEMS_DEF + 1)
) (
	input  logic             clk,
	input  scan_ctl_t        ctl,
	input  logic [SUM_W-1:0] head,
	input  logic [SUM_W-1:0] tail,
	input  logic [IDX_W-1:0] idx,
	output logic [SUM_W-1:0] best,
	output logic [IDX_W-1:0] best_idx
);

	logic [SUM_W-1:0] best_q;
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] cand;
	logic             take;

	assign cand = (head > tail) ? head : tail;
	// Strict compare: the earliest split point keeps a tie.
	assign take = ctl.restart || (cand < best_q);

	always_ff @(posedge clk) begin
		if (ctl.valid && take) begin
			best_q <= cand;
			idx_q  <= idx;
		end
	end

	assign best     = best_q;
	assign best_idx = idx_q;

endmodule

// ===== rtl/linear_partition_min_max_sum.sv =====
// Splits a sequence of unsigned values into group_count contiguous groups so that the largest
// group sum is as small as possible. Values arrive one per start transaction, one per cycle
// while busy is low; the item with last set closes the sequence and starts the solve, and busy
// stays high until every result has been shown. Up to MAX_ITEMS values are held; further ones
// are dropped and reported through overflow. For n held values and k groups (group_count, with
// 0 taken as 1 and values above MAX_GROUPS taken as MAX_GROUPS) the solve runs only when n and
// k are both at least 2, and the cost table memory serves one split candidate per cycle. The
// walk back through the split points then runs from the last group to the first, and the k
// results follow on consecutive cycles, each marked by result_valid for exactly one cycle, in
// group order; the receiver cannot stall them, so it must take every strobe. Busy falls in the
// cycle right after the final result. The group count register can be written on any cycle and
// should be written only while busy is low. The memories need no clearing after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module linear_partition_min_max_sum import lpmm_pkg::*; #(
	parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
	parameter int MAX_GROUPS  = MAX_GROUPS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int SUM_W      = VALUE_WIDTH + $clog2(MAX_ITEMS),
	localparam int END_W      = $clog2(MAX_ITEMS + 1),
	localparam int GIDX_W     = $clog2(MAX_GROUPS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic                   result_valid,
	output logic [SUM_W-1:0]       max_group_sum,
	output logic [GIDX_W-1:0]      group_index,
	output logic [END_W-1:0]       group_end,
	output logic                   overflow,
	output logic                   last_result
);

	localparam int ROW_W     = $clog2(MAX_ITEMS);
	localparam int COL_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int TBL_W     = SUM_W + END_W;
	localparam int TBL_DEPTH = 1 << (ROW_W + COL_W);

	lpmm_state_t state_q, state_d;

	logic [CFG_W-1:0]       group_count_q;
	logic [END_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       sum_q;
	logic [VALUE_WIDTH-1:0] first_value_q;
	logic                   ovf_q;

	logic [GIDX_W-1:0] k_q;
	logic [END_W-1:0]  i_q;
	logic [GIDX_W-1:0] j_q;
	logic [END_W-1:0]  l_q;
	logic [SUM_W-1:0]  pi_q;
	logic [SUM_W-1:0]  best_q;
	logic [GIDX_W-1:0] g_q;
	logic [END_W-1:0]  end_q;

	scan_ctl_t         scan_ctl_s1;
	logic [END_W-1:0]  l_s1;
	logic              emit_s1;
	logic [GIDX_W-1:0] gidx_s1;
	logic              lastr_s1;

	// Prefix sums: entry e holds the sum of the first e + 1 values.
	logic [SUM_W-1:0] pfx_mem [MAX_ITEMS];
	logic [SUM_W-1:0] pfx_rd_q;
	// Cost and split point of cell (row, group) at address {row - 1, group - 1}.
	logic [TBL_W-1:0] tbl_mem [TBL_DEPTH];
	logic [TBL_W-1:0] tbl_rd_q;
	// Last element of each group, filled from the last group backwards.
	logic [END_W-1:0] ends_mem [MAX_GROUPS];
	logic [END_W-1:0] ends_rd_q;

	logic                    accept;
	logic                    load_ok;
	logic [SUM_W-1:0]        sum_next;
	logic [SUM_W-1:0]        sum_new;
	logic [END_W-1:0]        n_next;
	logic [GIDX_W-1:0]       k_eff;
	logic                    pfx_we;
	logic [ROW_W-1:0]        pfx_wa;
	logic [ROW_W-1:0]        pfx_ra;
	logic                    tbl_we;
	logic [ROW_W+COL_W-1:0]  tbl_wa;
	logic [ROW_W+COL_W-1:0]  tbl_ra;
	logic                    ends_we;
	logic [COL_W-1:0]        ends_addr;
	logic [SUM_W-1:0]        tbl_cost;
	logic [END_W-1:0]        tbl_split;
	logic [SUM_W-1:0]        head;
	logic [SUM_W-1:0]        tail;
	logic [SUM_W-1:0]        scan_best;
	logic [END_W-1:0]        scan_idx;

	assign accept    = start && !busy;
	assign load_ok   = (cnt_q < END_W'(MAX_ITEMS));
	assign sum_next  = sum_q + SUM_W'(value);
	assign sum_new   = load_ok ? sum_next : sum_q;
	assign n_next    = load_ok ? (cnt_q + 1'b1) : cnt_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (group_count_q == '0) begin
			k_eff = GIDX_W'(1);
		end else if (int'(group_count_q) > MAX_GROUPS) begin
			k_eff = GIDX_W'(MAX_GROUPS);
		end else begin
			k_eff = GIDX_W'(group_count_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last) begin
					if (n_next >= 2 && k_eff >= 2) begin
						state_d = ST_ROW;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_ROW:   state_d = ST_PI;
			ST_PI:    state_d = ST_SCAN;
			ST_SCAN: begin
				if (l_q == i_q - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_WRITE;
			ST_WRITE: begin
				if (j_q != k_q) begin
					state_d = ST_SCAN;
				end else if (i_q == cnt_q) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_ROW;
				end
			end
			ST_WALK: begin
				if (g_q == GIDX_W'(1)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_WALK_NEXT;
				end
			end
			ST_WALK_NEXT: state_d = ST_WALK;
			ST_EMIT: begin
				if (g_q == k_q) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory controls and status.
	always_comb begin
		busy      = (state_q != ST_IDLE);
		pfx_we    = (state_q == ST_IDLE) && accept && load_ok;
		pfx_wa    = ROW_W'(cnt_q);
		pfx_ra    = ROW_W'(l_q - 1'b1);
		tbl_we    = (state_q == ST_WRITE);
		tbl_wa    = {ROW_W'(i_q - 1'b1), COL_W'(j_q - 1'b1)};
		tbl_ra    = {ROW_W'(l_q - 1'b1), COL_W'(j_q - 2'd2)};
		ends_we   = (state_q == ST_WALK);
		ends_addr = COL_W'(g_q - 1'b1);
		unique case (state_q)
			ST_ROW: begin
				pfx_ra = ROW_W'(i_q - 1'b1);
			end
			ST_WALK, ST_WALK_NEXT: begin
				tbl_ra = {ROW_W'(end_q - 1'b1), COL_W'(g_q - 1'b1)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pfx_we) begin
			pfx_mem[pfx_wa] <= sum_next;
		end
		pfx_rd_q <= pfx_mem[pfx_ra];
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= {scan_best, scan_idx};
		end
		tbl_rd_q <= tbl_mem[tbl_ra];
	end

	always_ff @(posedge clk) begin
		if (ends_we) begin
			ends_mem[ends_addr] <= end_q;
		end
		ends_rd_q <= ends_mem[ends_addr];
	end

	assign tbl_cost  = tbl_rd_q[TBL_W-1 -: SUM_W];
	assign tbl_split = tbl_rd_q[END_W-1:0];

	// The first column of costs is the prefix sum itself, and the first row is the first value,
	// so neither is stored in the table.
	always_comb begin
		if (j_q == 2) begin
			head = pfx_rd_q;
		end else if (scan_ctl_s1.restart) begin
			head = SUM_W'(first_value_q);
		end else begin
			head = tbl_cost;
		end
	end
	assign tail = pi_q - pfx_rd_q;

	lpmm_scan #(
		.SUM_W (SUM_W),
		.IDX_W (END_W)
	) u_scan (
		.clk      (clk),
		.ctl      (scan_ctl_s1),
		.head     (head),
		.tail     (tail),
		.idx      (l_s1),
		.best     (scan_best),
		.best_idx (scan_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			group_count_q <= GROUP_COUNT_RST;
			cnt_q         <= '0;
			sum_q         <= '0;
			first_value_q <= '0;
			ovf_q         <= 1'b0;
			scan_ctl_s1   <= '0;
			emit_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				group_count_q <= cfg_data;
			end
			if (accept && load_ok) begin
				cnt_q <= n_next;
				sum_q <= sum_next;
				if (cnt_q == '0) begin
					first_value_q <= value;
				end
			end
			if (accept && !load_ok) begin
				ovf_q <= 1'b1;
			end
			// The sequence is finished once the final result is out.
			if (state_q == ST_FLUSH) begin
				cnt_q         <= '0;
				sum_q         <= '0;
				first_value_q <= '0;
				ovf_q         <= 1'b0;
			end
			scan_ctl_s1.valid   <= (state_q == ST_SCAN);
			scan_ctl_s1.restart <= (l_q == END_W'(1));
			emit_s1             <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		l_s1     <= l_q;
		gidx_s1  <= g_q;
		lastr_s1 <= (g_q == k_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last) begin
					k_q    <= k_eff;
					i_q    <= END_W'(2);
					best_q <= sum_new;
					g_q    <= k_eff;
					end_q  <= n_next;
				end
			end
			ST_PI: begin
				pi_q <= pfx_rd_q;
				j_q  <= GIDX_W'(2);
				l_q  <= END_W'(1);
			end
			ST_SCAN: begin
				l_q <= l_q + 1'b1;
			end
			ST_WRITE: begin
				best_q <= scan_best;
				l_q    <= END_W'(1);
				if (j_q != k_q) begin
					j_q <= j_q + 1'b1;
				end else begin
					i_q   <= i_q + 1'b1;
					g_q   <= k_q;
					end_q <= cnt_q;
				end
			end
			ST_WALK_NEXT: begin
				end_q <= (end_q <= END_W'(1)) ? '0 : tbl_split;
				g_q   <= g_q - 1'b1;
			end
			ST_EMIT: begin
				g_q <= g_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result_valid  = emit_s1;
	assign max_group_sum = best_q;
	assign group_index   = gidx_s1;
	assign group_end     = ends_rd_q;
	assign overflow      = ovf_q;
	assign last_result   = lastr_s1;

	`ASSERT_SAME(a_result_in_busy, clk, arst_n, result_valid, busy, "result strobe while idle")
	`ASSERT_NEXT(a_last_starts_solve, clk, arst_n, start && !busy && last, busy,
		"final item did not start a solve")
	`ASSERT_NEXT(a_final_result_ends, clk, arst_n, result_valid && last_result, !result_valid,
		"result after the final group")
	`ASSERT_NEXT(a_results_contiguous, clk, arst_n, result_valid && !last_result, result_valid,
		"gap in the result burst")

endmodule

// ===== tb/tb_linear_partition_min_max_sum.sv =====
`timescale 1ns / 1ps
module tb_linear_partition_min_max_sum import lpmm_pkg::*;;

	localparam int CAP          = MAX_ITEMS_DEF;
	localparam int GROUPS       = MAX_GROUPS_DEF;
	localparam int RANDOM_ITEMS = 315;
	localparam int STALL_LIMIT  = 100000;

	typedef struct packed {
		logic [21:0] max_sum;
		logic [4:0]  gidx;
		logic [6:0]  gend;
		logic        ovf;
		logic        final_group;
	} group_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [15:0]      value;
	logic             last;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic             result_valid;
	logic [21:0]      max_group_sum;
	logic [4:0]       group_index;
	logic [6:0]       group_end;
	logic             overflow;
	logic             last_result;

	group_result_t   expected_groups[$];
	logic [CFG_W-1:0] model_groups;
	int unsigned     model_count;
	longint unsigned model_first;
	bit              model_ovf;
	longint unsigned model_prefix[0:CAP];
	longint unsigned model_cost[0:CAP][0:GROUPS];
	int unsigned     model_split[0:CAP][0:GROUPS];

	int mismatches;
	int items_sent;
	int idle_cycles;
	bit steady;

	linear_partition_min_max_sum DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.max_group_sum(max_group_sum),
		.group_index(group_index),
		.group_end(group_end),
		.overflow(overflow),
		.last_result(last_result)
	);

	always #4 clk = ~clk;

	// Loads one value and, on the closing item, solves the partition and queues one
	// expected result per group.
	function automatic void predict_partition(input logic [15:0] v, input logic is_last);
		int unsigned n;
		int unsigned k;
		int unsigned where;
		int unsigned e;
		int g;
		longint unsigned best;
		longint unsigned tail;
		longint unsigned head;
		longint unsigned m;
		int unsigned ends[0:GROUPS];
		group_result_t r;
		if (model_count < CAP) begin
			model_count++;
			model_prefix[model_count] = model_prefix[model_count - 1] + v;
			if (model_count == 1)
				model_first = v;
		end else begin
			model_ovf = 1'b1;
		end
		if (!is_last)
			return;
		n = model_count;
		k = model_groups;
		if (k == 0)
			k = 1;
		if (k > GROUPS)
			k = GROUPS;
		model_prefix[0] = 0;
		for (int unsigned i = 1; i <= n; i++)
			model_cost[i][1] = model_prefix[i];
		for (int unsigned j = 1; j <= k; j++)
			model_cost[1][j] = model_first;
		for (int unsigned i = 2; i <= n; i++) begin
			for (int unsigned j = 2; j <= k; j++) begin
				best = '1;
				where = 0;
				for (int unsigned l = 1; l < i; l++) begin
					tail = model_prefix[i] - model_prefix[l];
					head = model_cost[l][j - 1];
					m = (head > tail) ? head : tail;
					// Only a strictly smaller cost moves the split point.
					if (m < best) begin
						best = m;
						where = l;
					end
				end
				model_cost[i][j] = best;
				model_split[i][j] = where;
			end
		end
		best = model_cost[n][k];
		e = n;
		for (g = k; g >= 1; g--) begin
			ends[g] = e;
			e = (e <= 1 || e > CAP) ? 0 : model_split[e][g];
		end
		for (int unsigned gi = 1; gi <= k; gi++) begin
			r.max_sum = best[21:0];
			r.gidx = gi[4:0];
			r.gend = ends[gi][6:0];
			r.ovf = model_ovf;
			r.final_group = (gi == k);
			expected_groups.push_back(r);
		end
		model_count = 0;
		model_first = 0;
		model_ovf = 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		group_result_t want;
		if (arst_n && result_valid) begin
			if (expected_groups.size() == 0) begin
				report_mismatch("unexpected result, group_index", group_index, 0);
			end else begin
				want = expected_groups.pop_front();
				if (max_group_sum !== want.max_sum)
					report_mismatch("max_group_sum", max_group_sum, want.max_sum);
				if (group_index !== want.gidx)
					report_mismatch("group_index", group_index, want.gidx);
				if (group_end !== want.gend)
					report_mismatch("group_end", group_end, want.gend);
				if (overflow !== want.ovf)
					report_mismatch("overflow", overflow, want.ovf);
				if (last_result !== want.final_group)
					report_mismatch("last_result", last_result, want.final_group);
			end
		end
	end

	// A cycle counts as progress when any transaction or result strobe occurs.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [15:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 16'h0000;
		if (r < 24)
			return 16'hFFFF;
		if (r < 44)
			return 16'($urandom_range(0, 7));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_value(input logic [15:0] v, input logic is_last);
		if (!steady) begin
			while ($urandom_range(0, 99) < 24) begin
				@(negedge clk);
				start = 1'b0;
			end
		end
		@(negedge clk);
		start = 1'b1;
		value = v;
		last = is_last;
		do @(posedge clk); while (busy);
		predict_partition(v, is_last);
		items_sent++;
		if (is_last) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic write_group_count(input logic [CFG_W-1:0] v);
		while (expected_groups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		model_groups = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_reset_group_count();
		// One element split into the reset count of groups leaves leading groups empty.
		send_value(16'hFFFF, 1'b1);
	endtask

	task automatic test_single_group();
		write_group_count(5'd0);
		send_value(16'h0000, 1'b0);
		send_value(16'hFFFF, 1'b0);
		send_value(16'd7, 1'b1);
		write_group_count(5'd1);
		send_value(16'hFFFF, 1'b1);
	endtask

	task automatic test_more_groups_than_items();
		write_group_count(5'd31);
		send_value(16'd10, 1'b0);
		send_value(16'd20, 1'b0);
		send_value(16'd30, 1'b1);
		write_group_count(5'd17);
		send_value(16'h0000, 1'b0);
		send_value(16'h0000, 1'b1);
	endtask

	task automatic test_tied_costs();
		write_group_count(5'd2);
		repeat (3) send_value(16'd5, 1'b0);
		send_value(16'd5, 1'b1);
		write_group_count(5'd3);
		send_value(16'hFFFF, 1'b0);
		send_value(16'hFFFF, 1'b0);
		send_value(16'h0000, 1'b0);
		send_value(16'h0000, 1'b0);
		send_value(16'hFFFF, 1'b1);
	endtask

	task automatic test_capacity();
		// The closing item here is itself dropped but still starts the solve.
		write_group_count(5'd2);
		for (int i = 1; i <= CAP + 2; i++)
			send_value(pick_value(), i == CAP + 2);
		write_group_count(5'd16);
		for (int i = 1; i <= CAP; i++)
			send_value(16'($urandom_range(0, 65535)), i == CAP);
	endtask

	task automatic test_random();
		int first_item;
		int seq_no;
		int len;
		int r;
		logic [CFG_W-1:0] k;
		first_item = items_sent;
		seq_no = 0;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			if (seq_no % 3 == 0) begin
				r = $urandom_range(0, 9);
				case (r)
					0: k = 5'd0;
					1: k = 5'd31;
					2: k = 5'($urandom_range(17, 30));
					3: k = 5'd16;
					default: k = 5'($urandom_range(1, 15));
				endcase
				write_group_count(k);
			end
			steady = (seq_no >= 6 && seq_no < 12);
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(1, 8);
			else if (r < 90)
				len = $urandom_range(9, 24);
			else
				len = $urandom_range(25, CAP + 6);
			for (int i = 1; i <= len; i++)
				send_value(pick_value(), i == len);
			seq_no++;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		last = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		model_groups = GROUP_COUNT_RST;
		model_count = 0;
		model_first = 0;
		model_ovf = 1'b0;
		mismatches = 0;
		items_sent = 0;
		steady = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_group_count();
		test_single_group();
		test_more_groups_than_items();
		test_tied_costs();
		test_capacity();
		test_random();

		while (expected_groups.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpmm_pkg.sv
rtl/lpmm_scan.sv
rtl/linear_partition_min_max_sum.sv
tb/tb_linear_partition_min_max_sum.sv
